// ===== hw/rtl/tccw_pkg.sv =====
// Shared types and constants for the text console cell writer.
// Used by every module under hw/rtl; depends on nothing else.
package tccw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam int ROW_FIELD_W  = 5;
    localparam int COL_FIELD_W  = 7;
    localparam int CELL_INDEX_W = 11;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [15:0] RESET_CELL   = 16'h0F20;
    localparam logic [3:0]  RESET_FG     = 4'hF;
    localparam logic [3:0]  RESET_BG     = 4'h0;

    localparam logic REG_FOREGROUND = 1'b0;
    localparam logic REG_BACKGROUND = 1'b1;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_READ
    } op_t;

    typedef struct packed {
        logic                    command;
        logic [7:0]              char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } cmd_t;

    typedef struct packed {
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_column;
        logic [15:0]            read_cell;
        logic                   scrolled;
    } result_t;

    typedef struct packed {
        op_t                     op;
        logic [7:0]              char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } op_item_t;

    typedef struct packed {
        logic [3:0] foreground;
        logic [3:0] background;
    } colour_cfg_t;

endpackage

// ===== hw/rtl/tccw_cfg.sv =====
// APB register file holding the foreground and background colour indices.
// Depends on tccw_pkg.
module tccw_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tccw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tccw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tccw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output tccw_pkg::colour_cfg_t            colours
);

    logic [3:0] fg_reg;
    logic [3:0] fg_next;
    logic [3:0] bg_reg;
    logic [3:0] bg_next;
    logic       reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite;

    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        prdata  = '0;
        case (reg_index)
            tccw_pkg::REG_FOREGROUND:
            begin
                prdata = tccw_pkg::APB_DATA_W'(fg_reg);
                if (wr_en)
                begin
                    fg_next = pwdata[3:0];
                end
            end
            tccw_pkg::REG_BACKGROUND:
            begin
                prdata = tccw_pkg::APB_DATA_W'(bg_reg);
                if (wr_en)
                begin
                    bg_next = pwdata[3:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= tccw_pkg::RESET_FG;
            bg_reg <= tccw_pkg::RESET_BG;
        end
        else
        begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    assign colours.foreground = fg_reg;
    assign colours.background = bg_reg;

endmodule

// ===== hw/rtl/tccw_front.sv =====
// Front end: accepts command items, classifies them and hands them to the queue.
// Depends on tccw_pkg.
module tccw_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tccw_pkg::cmd_t      cmd,
    output logic                full,
    input  logic                busy,
    input  logic                q_full,
    output logic                q_push,
    output tccw_pkg::op_item_t  q_data
);

    logic               valid_reg;
    logic               valid_next;
    tccw_pkg::op_item_t item_reg;
    tccw_pkg::op_item_t item_next;
    logic               accept;

    assign full   = busy || (valid_reg && q_full);
    assign accept = push && !full;
    assign q_push = valid_reg;
    assign q_data = item_reg;

    always_comb
    begin
        valid_next           = valid_reg;
        item_next            = item_reg;
        item_next.char_code  = cmd.char_code;
        item_next.cell_index = cmd.cell_index;
        if (cmd.command == tccw_pkg::CMD_READ)
        begin
            item_next.op = tccw_pkg::OP_READ;
        end
        else if (cmd.char_code == tccw_pkg::NEWLINE_CODE)
        begin
            item_next.op = tccw_pkg::OP_NEWLINE;
        end
        else
        begin
            item_next.op = tccw_pkg::OP_PUT;
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            item_next = item_reg;
            if (valid_reg && !q_full)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== hw/rtl/tccw_queue.sv =====
// Short queue of classified items between the front end and the back end.
// Depends on tccw_pkg.
module tccw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tccw_pkg::op_item_t  push_data,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output tccw_pkg::op_item_t  head
);

    localparam int DEPTH = tccw_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tccw_pkg::op_item_t slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/tccw_back.sv =====
// Back end: owns the cell store and cursor, executes items, scrolls and clears.
// Depends on tccw_pkg.
module tccw_back #(
    parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tccw_pkg::colour_cfg_t  colours,
    input  logic                   q_empty,
    input  tccw_pkg::op_item_t     q_head,
    output logic                   q_pop,
    output logic                   busy,
    output logic                   empty,
    input  logic                   pop,
    output tccw_pkg::result_t      result
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_END = ADDR_W'(CELLS - COLUMNS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FLUSH
    } state_t;

    logic [15:0] mem [CELLS];

    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic              pipe_valid_reg;
    logic              pipe_valid_next;
    logic              pipe_blank_reg;
    logic              pipe_blank_next;
    logic [ADDR_W-1:0] pipe_addr_reg;
    logic [ADDR_W-1:0] pipe_addr_next;
    logic              rd_ok_reg;
    logic              rd_ok_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    tccw_pkg::result_t out_item_reg;
    tccw_pkg::result_t out_item_next;
    logic [15:0]       rd_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic              take;
    logic              do_line;
    logic              res_load;
    logic              res_scrolled;
    logic [15:0]       res_cell;
    logic [7:0]        attr;
    logic [15:0]       blank_cell;
    logic [ADDR_W-1:0] put_addr;
    logic [31:0]       cell_wide;
    logic [31:0]       row_wide;
    logic [31:0]       col_wide;

    assign attr       = {colours.background, colours.foreground};
    assign blank_cell = {attr, tccw_pkg::SPACE_CODE};
    assign put_addr   = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);
    assign cell_wide  = 32'(q_head.cell_index);
    assign row_wide   = 32'(row_next);
    assign col_wide   = 32'(col_next);
    assign take       = (state_reg == ST_IDLE) && !q_empty && (!out_valid_reg || pop);
    assign busy       = (state_reg == ST_CLEAR);
    assign empty      = !out_valid_reg;
    assign result     = out_item_reg;

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        pipe_valid_next = pipe_valid_reg;
        pipe_blank_next = pipe_blank_reg;
        pipe_addr_next  = pipe_addr_reg;
        rd_ok_next      = rd_ok_reg;
        mem_we          = 1'b0;
        mem_waddr       = pipe_addr_reg;
        mem_wdata       = pipe_blank_reg ? blank_cell : rd_data_reg;
        mem_raddr       = addr_reg;
        q_pop           = 1'b0;
        do_line         = 1'b0;
        res_load        = 1'b0;
        res_scrolled    = 1'b0;
        res_cell        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = tccw_pkg::RESET_CELL;
                if (addr_reg == LAST_A)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        tccw_pkg::OP_READ:
                        begin
                            mem_raddr  = cell_wide[ADDR_W-1:0];
                            rd_ok_next = (cell_wide < 32'(CELLS));
                            state_next = ST_READ;
                        end
                        tccw_pkg::OP_PUT:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = put_addr;
                            mem_wdata = {attr, q_head.char_code};
                            if (col_reg == LAST_COL)
                            begin
                                do_line = 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                                res_load = 1'b1;
                            end
                        end
                        tccw_pkg::OP_NEWLINE:
                        begin
                            do_line = 1'b1;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                    if (do_line)
                    begin
                        col_next = '0;
                        if (row_reg == LAST_ROW)
                        begin
                            addr_next  = '0;
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                            res_load = 1'b1;
                        end
                    end
                end
            end
            ST_READ:
            begin
                res_load   = 1'b1;
                res_cell   = rd_ok_reg ? rd_data_reg : 16'h0000;
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                mem_we          = pipe_valid_reg;
                pipe_valid_next = 1'b1;
                pipe_addr_next  = addr_reg;
                pipe_blank_next = (addr_reg >= COPY_END);
                mem_raddr       = (addr_reg >= COPY_END) ? addr_reg : addr_reg + COLS_A;
                if (addr_reg == LAST_A)
                begin
                    addr_next  = '0;
                    state_next = ST_FLUSH;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                mem_we          = pipe_valid_reg;
                pipe_valid_next = 1'b0;
                res_load        = 1'b1;
                res_scrolled    = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next               = out_valid_reg;
        out_item_next                = out_item_reg;
        out_item_next.cursor_row     = row_wide[tccw_pkg::ROW_FIELD_W-1:0];
        out_item_next.cursor_column  = col_wide[tccw_pkg::COL_FIELD_W-1:0];
        out_item_next.read_cell      = res_cell;
        out_item_next.scrolled       = res_scrolled;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_item_next = out_item_reg;
            if (pop)
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            pipe_blank_reg <= 1'b0;
            rd_ok_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            pipe_valid_reg <= pipe_valid_next;
            pipe_blank_reg <= pipe_blank_next;
            rd_ok_reg      <= rd_ok_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_addr_reg <= pipe_addr_next;
        out_item_reg  <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= LAST_ROW) && (col_reg <= LAST_COL))
        else $error("cursor outside the store");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_scrolled) |=> (row_reg == LAST_ROW) && (col_reg == '0))
        else $error("scroll left cursor off the last row start");

    a_scroll_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL) |-> !out_valid_reg)
        else $error("result pending during scroll");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_waddr <= LAST_A))
        else $error("store write beyond last cell");

endmodule

// ===== hw/rtl/text_console_cell_writer_unit.sv =====
// Text console cell writer: a ROWS x COLUMNS store of attribute/character cells
// with a cursor, fed through a command queue and read back through a result queue.
//
// Channels: command items enter on push/full (command, char_code, cell_index);
// one result item per command leaves on empty/pop (cursor_row, cursor_column,
// read_cell, scrolled). Colours are set through the APB port: foreground at
// byte address 0, background at byte address 4, both reset to white on black.
// A command is registered in the front end and queued before the back end runs
// it. Puts and newlines sustain one item per cycle while results are popped and
// no scroll runs; a read waits in its own state on the registered store read.
// A put or newline that moves past the last row scrolls the store: one copy
// pass through the store's ports.
// Reset: cursor to the top left, store cleared to 0x0F20 by a pass over every cell
// during which full stays high; APB writes are taken throughout.
// Stall: when the receiver stops popping, one result waits in the output
// register while up to three more commands are held in the front end and queue,
// after which full rises.
module text_console_cell_writer_unit #(
    parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tccw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tccw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tccw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             push,
    output logic                             full,
    input  tccw_pkg::cmd_t                   cmd,
    output logic                             empty,
    input  logic                             pop,
    output tccw_pkg::result_t                result
);

    tccw_pkg::colour_cfg_t colours;
    tccw_pkg::op_item_t    fq_data;
    tccw_pkg::op_item_t    q_head;
    logic                  fq_push;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic                  busy;

    tccw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .colours (colours)
    );

    tccw_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cmd    (cmd),
        .full   (full),
        .busy   (busy),
        .q_full (q_full),
        .q_push (fq_push),
        .q_data (fq_data)
    );

    tccw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fq_push),
        .push_data (fq_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .colours (colours),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .busy    (busy),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== verif/text_console_cell_writer_unit_test.sv =====
// Self-checking testbench for text_console_cell_writer_unit: directed and random command items,
// colour register writes over APB, results checked against a screen predictor held here.
// Depends on tccw_pkg and the text_console_cell_writer_unit RTL only.
module text_console_cell_writer_unit_test;
    import tccw_pkg::*;

    localparam int COLUMNS = DEF_COLUMNS;
    localparam int ROWS    = DEF_ROWS;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int PHASES  = 6;

    typedef struct {
        logic                    command;
        logic [7:0]              char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
        int                      reps;
        bit                      known;
        result_t                 want;
    } directed_step_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push;
    logic                  full;
    cmd_t                  cmd;
    logic                  empty;
    logic                  pop;
    result_t               result;

    logic [15:0] screen_cells [CELLS];
    int          cur_row;
    int          cur_col;
    logic [3:0]  fg_colour;
    logic [3:0]  bg_colour;
    result_t     pending_results [$];
    int          mismatches = 0;
    int          send_idle = 0;
    int          recv_idle = 0;

    directed_step_t script [18];

    text_console_cell_writer_unit DUT (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("text_console_cell_writer_unit test failed");
        $finish;
    end

    function automatic bit next_line();
        cur_col = 0;
        if (cur_row + 1 >= ROWS)
        begin
            cur_row = ROWS - 1;
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen_cells[i] = screen_cells[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen_cells[i] = {bg_colour, fg_colour, SPACE_CODE};
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    function automatic result_t console_predict(cmd_t c);
        result_t r;
        r = '0;
        if (c.command == CMD_READ)
        begin
            if (int'(c.cell_index) < CELLS)
                r.read_cell = screen_cells[c.cell_index];
        end
        else if (c.char_code == NEWLINE_CODE)
            r.scrolled = next_line();
        else
        begin
            screen_cells[cur_row * COLUMNS + cur_col] = {bg_colour, fg_colour, c.char_code};
            cur_col++;
            if (cur_col >= COLUMNS)
                r.scrolled = next_line();
        end
        r.cursor_row    = ROW_FIELD_W'(cur_row);
        r.cursor_column = COL_FIELD_W'(cur_col);
        return r;
    endfunction

    task automatic send_cmd(cmd_t c, bit known, result_t want);
        result_t predicted;
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        cmd  <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predicted = console_predict(c);
        pending_results.push_back(known ? want : predicted);
    endtask

    // hold off until every result is back and any scroll pass has finished
    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (CELLS + 16) @(posedge clk);
    endtask

    task automatic colour_write(logic reg_sel, logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {28'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_sel == REG_FOREGROUND)
            fg_colour = value;
        else
            bg_colour = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {28'b0, value})
        begin
            $display("%0t colour register %0d expected %0h actual %0h",
                     $time, reg_sel, value, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(int quota);
        int      sent;
        int      n;
        int      pick;
        cmd_t    c;
        result_t none;
        sent = 0;
        none = '0;
        while (sent < quota)
        begin
            pick = $urandom_range(9);
            if (pick <= 5)
            begin
                n = ($urandom_range(3) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 20);
                c.command = CMD_PUT;
                repeat (n)
                begin
                    if ($urandom_range(7) == 0)
                        c.char_code = 8'($urandom);
                    else
                        c.char_code = 8'($urandom_range(8'h20, 8'h7E));
                    if (c.char_code == NEWLINE_CODE)
                        c.char_code = SPACE_CODE;
                    c.cell_index = CELL_INDEX_W'($urandom);
                    send_cmd(c, 1'b0, none);
                    sent++;
                end
                c.char_code  = NEWLINE_CODE;
                c.cell_index = CELL_INDEX_W'($urandom);
                send_cmd(c, 1'b0, none);
                sent++;
            end
            else if (pick <= 8)
            begin
                n = $urandom_range(1, 6);
                c.command = CMD_READ;
                repeat (n)
                begin
                    pick = $urandom_range(5);
                    if (pick <= 2)
                        c.cell_index = CELL_INDEX_W'($urandom_range(CELLS - 1));
                    else if (pick <= 4)
                        c.cell_index = CELL_INDEX_W'($urandom_range(CELLS - 2 * COLUMNS,
                                                                    CELLS - 1));
                    else
                        c.cell_index = CELL_INDEX_W'($urandom);
                    c.char_code = 8'($urandom);
                    send_cmd(c, 1'b0, none);
                    sent++;
                end
            end
            else
            begin
                c.command    = 1'($urandom);
                c.char_code  = 8'($urandom);
                c.cell_index = CELL_INDEX_W'($urandom);
                send_cmd(c, 1'b0, none);
                sent++;
            end
        end
    endtask

    initial
    begin
        result_t got;
        result_t want;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got = result;
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected item expected none actual %h", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.cursor_row !== want.cursor_row)
                    begin
                        $display("%0t cursor_row expected %0d actual %0d",
                                 $time, want.cursor_row, got.cursor_row);
                        mismatches++;
                    end
                    if (got.cursor_column !== want.cursor_column)
                    begin
                        $display("%0t cursor_column expected %0d actual %0d",
                                 $time, want.cursor_column, got.cursor_column);
                        mismatches++;
                    end
                    if (got.read_cell !== want.read_cell)
                    begin
                        $display("%0t read_cell expected %h actual %h",
                                 $time, want.read_cell, got.read_cell);
                        mismatches++;
                    end
                    if (got.scrolled !== want.scrolled)
                    begin
                        $display("%0t scrolled expected %b actual %b",
                                 $time, want.scrolled, got.scrolled);
                        mismatches++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        cmd_t       c;
        logic [3:0] fg_plan [PHASES];
        logic [3:0] bg_plan [PHASES];
        fg_plan = '{4'd0, 4'd15, 4'd3, 4'd0, 4'd15, 4'd9};
        bg_plan = '{4'd0, 4'd15, 4'd12, 4'd0, 4'd0, 4'd6};
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        push    <= 1'b0;
        cmd     <= '0;
        foreach (screen_cells[i])
            screen_cells[i] = RESET_CELL;
        cur_row   = 0;
        cur_col   = 0;
        fg_colour = RESET_FG;
        bg_colour = RESET_BG;

        script = '{
            '{CMD_READ, 8'h00,        11'd0,    1,  1'b1, '{5'd0,  7'd0, 16'h0F20, 1'b0}},
            '{CMD_READ, 8'h00,        11'd1999, 1,  1'b1, '{5'd0,  7'd0, 16'h0F20, 1'b0}},
            '{CMD_READ, 8'h00,        11'd2000, 1,  1'b1, '{5'd0,  7'd0, 16'h0000, 1'b0}},
            '{CMD_READ, 8'hFF,        11'd2047, 1,  1'b1, '{5'd0,  7'd0, 16'h0000, 1'b0}},
            '{CMD_PUT,  8'h41,        11'd2047, 1,  1'b1, '{5'd0,  7'd1, 16'h0000, 1'b0}},
            '{CMD_PUT,  8'h00,        11'd0,    1,  1'b1, '{5'd0,  7'd2, 16'h0000, 1'b0}},
            '{CMD_PUT,  8'hFF,        11'd0,    1,  1'b1, '{5'd0,  7'd3, 16'h0000, 1'b0}},
            '{CMD_READ, 8'h00,        11'd0,    1,  1'b1, '{5'd0,  7'd3, 16'h0F41, 1'b0}},
            '{CMD_READ, 8'h00,        11'd2,    1,  1'b1, '{5'd0,  7'd3, 16'h0FFF, 1'b0}},
            '{CMD_READ, 8'h00,        11'd1,    1,  1'b1, '{5'd0,  7'd3, 16'h0F00, 1'b0}},
            '{CMD_PUT,  NEWLINE_CODE, 11'd0,    1,  1'b1, '{5'd1,  7'd0, 16'h0000, 1'b0}},
            '{CMD_PUT,  NEWLINE_CODE, 11'd0,    23, 1'b0, '0},
            '{CMD_PUT,  8'h42,        11'd0,    1,  1'b1, '{5'd24, 7'd1, 16'h0000, 1'b0}},
            '{CMD_PUT,  NEWLINE_CODE, 11'd2047, 1,  1'b1, '{5'd24, 7'd0, 16'h0000, 1'b1}},
            '{CMD_READ, 8'h00,        11'd1840, 1,  1'b1, '{5'd24, 7'd0, 16'h0F42, 1'b0}},
            '{CMD_READ, 8'h00,        11'd1920, 1,  1'b1, '{5'd24, 7'd0, 16'h0F20, 1'b0}},
            '{CMD_READ, 8'h00,        11'd1,    1,  1'b0, '0},
            '{CMD_READ, NEWLINE_CODE, 11'd1023, 1,  1'b0, '0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[k])
        begin
            c.command    = script[k].command;
            c.char_code  = script[k].char_code;
            c.cell_index = script[k].cell_index;
            repeat (script[k].reps)
                send_cmd(c, script[k].known, script[k].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            if (p == 3)
            begin
                fg_plan[p] = 4'($urandom);
                bg_plan[p] = 4'($urandom);
            end
            colour_write(REG_FOREGROUND, fg_plan[p]);
            colour_write(REG_BACKGROUND, bg_plan[p]);
            if (p < 2)
            begin
                send_idle = 17;
                recv_idle = 69;
            end
            else if (p < 4)
            begin
                send_idle = 69;
                recv_idle = 17;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            random_phase(80);
        end

        drain_results();
        if (mismatches == 0)
            $display("text_console_cell_writer_unit test passed");
        else
            $display("text_console_cell_writer_unit test failed");
        $finish;
    end

endmodule
